FILE: rtl/sha256_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants for the byte-serial SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned ROUNDS      = 64;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;
	localparam logic [5:0]  LEN_POS     = 6'd56;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		SRC_DATA = 2'b00,
		SRC_PAD  = 2'b01,
		SRC_ZERO = 2'b10,
		SRC_LEN  = 2'b11
	} byte_src_t;

	// controller to datapath commands
	typedef struct packed {
		logic      push;      // write one byte into the block buffer
		byte_src_t src;
		logic      count_len; // add eight bits to the length
		logic      comp_start;
		logic      round;     // run one compression round
		logic      comp_end;  // add working vars into the hash
		logic      clear;     // return to initial hash state
		logic      load_out;  // capture digest word
		logic [2:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] round_cnt;
	} dp_sts_t;

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage
`default_nettype wire

FILE: rtl/sha256_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer, rolling schedule, round unit, hash words and bit length.
// ----------------------------------------------------------------------------
module sha256_datapath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire [7:0]             data_byte,
	input  sha256_pkg::dp_cmd_t   cmd,
	output sha256_pkg::dp_sts_t   sts,
	output sha256_pkg::word_t     digest_q
);

	sha256_pkg::word_t w_q [16];
	sha256_pkg::word_t h_q [8];
	sha256_pkg::word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;

	logic [7:0]  push_val;
	logic [2:0]  len_sel;
	sha256_pkg::word_t w2, w15, s0, s1, wnew, wt, t1, t2, sig0, sig1, ch, maj;

	assign sts.fill      = fill_q;
	assign sts.round_cnt = rnd_q;
	assign len_sel       = fill_q[2:0];

	always_comb begin
		case (cmd.src)
			sha256_pkg::SRC_DATA: push_val = data_byte;
			sha256_pkg::SRC_PAD:  push_val = sha256_pkg::PAD_BYTE;
			sha256_pkg::SRC_ZERO: push_val = 8'h00;
			sha256_pkg::SRC_LEN:  push_val = len_q[8'(7 - len_sel) * 8 +: 8];
			default:              push_val = 8'h00;
		endcase
	end

	// message schedule
	assign w2   = w_q[4'(rnd_q[3:0] - 4'd2)];
	assign w15  = w_q[4'(rnd_q[3:0] - 4'd15)];
	assign s1   = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
	assign s0   = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
	assign wnew = s1 + w_q[4'(rnd_q[3:0] - 4'd7)] + s0 + w_q[rnd_q[3:0]];
	assign wt   = (rnd_q >= 6'd16) ? wnew : w_q[rnd_q[3:0]];

	// round function
	assign sig1 = {e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]};
	assign sig0 = {a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]};
	assign ch   = (e_q & f_q) ^ (~e_q & g_q);
	assign maj  = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
	assign t1   = hh_q + sig1 + ch + sha256_pkg::ROUND_K[rnd_q] + wt;
	assign t2   = sig0 + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rnd_q  <= '0;
			len_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_HASH[i];
		end else begin
			if (cmd.clear) begin
				fill_q <= '0;
				len_q  <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_HASH[i];
			end else begin
				if (cmd.count_len) len_q <= len_q + 64'd8;
				if (cmd.push) fill_q <= fill_q + 6'd1;
				if (cmd.comp_start) rnd_q <= '0;
				else if (cmd.round) rnd_q <= rnd_q + 6'd1;
				if (cmd.comp_end) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q;
					h_q[7] <= h_q[7] + hh_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.push)
			w_q[fill_q[5:2]][8'(3 - fill_q[1:0]) * 8 +: 8] <= push_val;
		if (cmd.round && rnd_q >= 6'd16)
			w_q[rnd_q[3:0]] <= wnew;
		if (cmd.comp_start) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end else if (cmd.round) begin
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
		if (cmd.load_out) digest_q <= h_q[cmd.out_idx];
	end

endmodule
`default_nettype wire

FILE: rtl/sha256_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer for byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid,
	output logic                 ready,
	input  wire                  has_byte,
	input  wire                  last_byte,
	input  sha256_pkg::dp_sts_t  sts,
	output sha256_pkg::dp_cmd_t  cmd,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [2:0]           out_idx_q
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_ADD   = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_LOAD  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   pad_q, pad_d;
	logic   zero_q, zero_d;       // pad marker already placed
	logic   spill_q, spill_d;     // pad marker in length field, length in next block
	logic [2:0] idx_d;
	logic   full;

	assign ready     = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign full      = (sts.fill == 6'(sha256_pkg::BLOCK_BYTES - 1));

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pad_d   = pad_q;
		zero_d  = zero_q;
		spill_d = spill_q;
		idx_d   = out_idx_q;
		cmd.out_idx = out_idx_q;
		case (state_q)
			ST_IDLE: begin
				if (valid) begin
					cmd.src = sha256_pkg::SRC_DATA;
					if (has_byte) begin
						cmd.push      = 1'b1;
						cmd.count_len = 1'b1;
					end
					if (last_byte) begin
						pad_d   = 1'b1;
						zero_d  = 1'b0;
						spill_d = 1'b0;
					end
					if (has_byte && full) state_d = ST_START;
					else if (last_byte) state_d = ST_PAD;
				end
			end
			ST_START: begin
				cmd.comp_start = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.round_cnt == 6'(sha256_pkg::ROUNDS - 1)) state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.comp_end = 1'b1;
				state_d = pad_q ? ST_PAD : ST_IDLE;
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (!zero_q) begin
					cmd.src = sha256_pkg::SRC_PAD;
					zero_d  = 1'b1;
					if (sts.fill >= sha256_pkg::LEN_POS) spill_d = 1'b1;
				end else if (!spill_q && sts.fill >= sha256_pkg::LEN_POS) begin
					cmd.src = sha256_pkg::SRC_LEN;
				end else begin
					cmd.src = sha256_pkg::SRC_ZERO;
				end
				if (full) begin
					state_d = ST_START;
					spill_d = 1'b0;
					if (zero_q && !spill_q && sts.fill >= sha256_pkg::LEN_POS) pad_d = 1'b0;
				end
			end
			ST_LOAD: begin
				cmd.load_out = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					if (out_idx_q == 3'd7) begin
						cmd.clear = 1'b1;
						idx_d   = 3'd0;
						state_d = ST_IDLE;
					end else begin
						idx_d   = out_idx_q + 3'd1;
						state_d = ST_LOAD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fin_q marks the final padded block; after its compression it selects output
	logic fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pad_q     <= 1'b0;
			zero_q    <= 1'b0;
			spill_q   <= 1'b0;
			fin_q     <= 1'b0;
			out_idx_q <= '0;
		end else begin
			pad_q     <= pad_d;
			zero_q    <= zero_d;
			spill_q   <= spill_d;
			out_idx_q <= idx_d;
			if (state_q == ST_PAD && state_d == ST_START && !pad_d) fin_q <= 1'b1;
			if (state_q == ST_ADD && fin_q) begin
				fin_q   <= 1'b0;
				state_q <= ST_LOAD;
			end else begin
				state_q <= state_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sha256_message_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Byte-serial SHA-256: pads, compresses and returns the eight digest words.
// ----------------------------------------------------------------------------
// A byte is taken only while the block is idle, not while a compression,
// padding or digest output runs; the 64th byte of a block starts the round
// unit, which does one round per cycle. On the end mark the block is padded
// one byte per cycle, one or two more compressions run, and digest words 0
// to 7 come out in order, each loaded into digest_word and held until the
// receiver takes it. The block then returns to its initial hash state.
module sha256_message_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         valid,
	output logic        ready,
	input  wire  [7:0]  data_byte,
	input  wire         has_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha256_pkg::dp_cmd_t cmd;
	sha256_pkg::dp_sts_t sts;
	logic [2:0] idx;

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .valid, .ready, .has_byte, .last_byte,
		.sts, .cmd, .out_valid, .out_ready, .out_idx_q(idx)
	);

	sha256_datapath u_dp (
		.clk, .arst_n, .data_byte, .cmd, .sts, .digest_q(digest_word)
	);

	assign word_index = idx;
	assign last_word  = (idx == 3'd7);

endmodule
`default_nettype wire

FILE: rtl/sha256_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the hasher's output sequencing.
// ----------------------------------------------------------------------------
module sha256_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] digest_word,
	input wire [2:0]  word_index,
	input wire        last_word
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ready && out_valid)) else $error("input taken during output");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7))) else $error("bad last flag");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> ##1
		(word_index == $past(word_index, 2) + 3'd1)) else $error("index skip");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
		else $error("word dropped");

endmodule

bind sha256_message_hasher sha256_checker u_chk (
	.clk, .arst_n, .ready, .out_valid, .out_ready, .digest_word, .word_index, .last_word
);
`default_nettype wire

FILE: tb/tb_sha256_message_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_message_hasher
// Feeds byte messages of varied length through the hasher under random idle
// and stall patterns, predicts each digest with an internal SHA-256 model and
// checks the eight digest words in order.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher;

	class digest_scoreboard;
		sha256_pkg::word_t hash_acc [8];
		logic [7:0]        blk [64];
		int unsigned       fill;
		logic [63:0]       bit_len;
		sha256_pkg::word_t pend_word [$];
		logic [2:0]        pend_idx [$];
		logic              pend_last [$];
		int                errors;

		function void clear_state();
			foreach (hash_acc[i]) hash_acc[i] = sha256_pkg::INIT_HASH[i];
			foreach (blk[i]) blk[i] = 8'h00;
			fill = 0;
			bit_len = '0;
		endfunction

		function sha256_pkg::word_t rotr(sha256_pkg::word_t x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			sha256_pkg::word_t w [64];
			sha256_pkg::word_t v [8];
			sha256_pkg::word_t t1, t2, s0, s1;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			foreach (v[i]) v[i] = hash_acc[i];
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + w[t];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			foreach (hash_acc[i]) hash_acc[i] += v[i];
		endfunction

		function void append(logic [7:0] b);
			blk[fill] = b;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		function void note_word(logic [7:0] b, logic has, logic fin);
			logic [63:0] len;
			if (has) begin
				append(b);
				bit_len += 64'd8;
			end
			if (!fin)
				return;
			len = bit_len;
			append(sha256_pkg::PAD_BYTE);
			while (fill != sha256_pkg::LEN_POS)
				append(8'h00);
			for (int i = 0; i < 8; i++)
				append(len[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				pend_word.push_back(hash_acc[i]);
				pend_idx.push_back(3'(i));
				pend_last.push_back(i == 7);
			end
			clear_state();
		endfunction

		function void check_word(sha256_pkg::word_t dw, logic [2:0] idx, logic lw);
			if (pend_word.size() == 0) begin
				$error("digest word with nothing expected: %h", dw);
				errors++;
				return;
			end
			if (dw !== pend_word[0]) begin
				$error("digest_word exp %h got %h", pend_word[0], dw);
				errors++;
			end
			if (idx !== pend_idx[0]) begin
				$error("word_index exp %0d got %0d", pend_idx[0], idx);
				errors++;
			end
			if (lw !== pend_last[0]) begin
				$error("last_word exp %0d got %0d", pend_last[0], lw);
				errors++;
			end
			void'(pend_word.pop_front());
			void'(pend_idx.pop_front());
			void'(pend_last.pop_front());
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid = 1'b0;
	logic        ready;
	logic [7:0]  data_byte = '0;
	logic        has_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;

	always #5 clk = ~clk;

	sha256_message_hasher dut (
		.clk, .arst_n, .valid, .ready, .data_byte, .has_byte, .last_byte,
		.out_valid, .out_ready, .digest_word, .word_index, .last_word
	);

	// receiver
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(digest_word, word_index, last_word);
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_word(logic [7:0] b, logic has, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			valid <= 1'b0;
			@(posedge clk);
		end
		valid     <= 1'b1;
		data_byte <= b;
		has_byte  <= has;
		last_byte <= fin;
		do @(posedge clk); while (!ready);
		sb.note_word(b, has, fin);
	endtask

	task automatic send_message(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_word(8'($urandom), 1'b0, 1'b0);
			send_word(8'($urandom), 1'b1, (i == n - 1));
		end
		if (n == 0)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic set_phase(int s, int r);
		send_idle_pct  = s;
		recv_stall_pct = r;
	endtask

	initial begin
		#2000000;
		$display("tb_sha256_message_hasher: FAIL");
		$finish;
	end

	initial begin
		int len;
		int wait_cnt;
		sb = new();
		sb.clear_state();
		sb.errors = 0;
		hold_off = 1'b0;
		set_phase(0, 0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, empty items, edge bytes
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hff, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'h5a, 1'b1, 1'b1);
		send_word(8'ha5, 1'b1, 1'b1);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'h3c, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_phase(0, 0);
				1: set_phase(47, 0);
				2: set_phase(0, 47);
				default: set_phase(15, 15);
			endcase
			// long receiver hold-off so the block backs up
			if (ph == 2) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (600) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			case (ph)
				0: len = 55;
				1: len = $urandom_range(1, 8);
				2: len = 56;
				default: len = $urandom_range(1, 8);
			endcase
			send_message(len);
		end

		valid <= 1'b0;
		hold_off = 1'b0;
		wait_cnt = 0;
		while (sb.pend_word.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pend_word.size() == 0)
			$display("tb_sha256_message_hasher: PASS");
		else
			$display("tb_sha256_message_hasher: FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_ctrl.sv
rtl/sha256_message_hasher.sv
rtl/sha256_checker.sv
tb/tb_sha256_message_hasher.sv
